FILE: rtl/core/phbp_pkg.sv
// Shared types, constants and hash functions of the path-history branch predictor.
package phbp_pkg;

  localparam int unsigned PendingDepthDefault = 64;
  localparam int unsigned TableDepth = 256;

  localparam logic [1:0] FuncNone    = 2'd0;
  localparam logic [1:0] FuncBranch  = 2'd1;
  localparam logic [1:0] FuncOther   = 2'd2;
  localparam logic [1:0] FuncInvalid = 2'd3;

  localparam logic [2:0] RegFamily  = 3'd0;
  localparam logic [2:0] RegHash    = 3'd1;
  localparam logic [2:0] RegScope   = 3'd2;
  localparam logic [2:0] RegDelay   = 3'd3;
  localparam logic [2:0] RegBarrier = 3'd4;

  localparam logic [3:0] FamBimodal = 4'd0;
  localparam logic [3:0] FamGshare  = 4'd1;
  localparam logic [3:0] FamLastTgt = 4'd2;
  localparam logic [3:0] FamSrcPath = 4'd3;
  localparam logic [3:0] FamTgtPath = 4'd4;
  localparam logic [3:0] FamNextPc  = 4'd5;
  localparam logic [3:0] FamEdge    = 4'd6;
  localparam logic [3:0] FamTgtLast = 4'd7;
  localparam logic [3:0] FamTgtRoll = 4'd8;

  localparam logic [1:0] HashLow8  = 2'd0;
  localparam logic [1:0] HashFold8 = 2'd1;
  localparam logic [1:0] HashFold4 = 2'd2;
  localparam logic [1:0] HashFold2 = 2'd3;

  localparam logic [1:0] ScopeNone   = 2'd0;
  localparam logic [1:0] ScopeBranch = 2'd1;

  typedef struct packed {
    logic [1:0]  func;
    logic        taken;
    logic [31:0] source_address;
    logic [31:0] target_address;
    logic [31:0] next_address;
    logic [63:0] instruction_number;
  } in_item_t;

  typedef struct packed {
    logic       pred_taken;
    logic       mispredicted;
    logic [7:0] table_index;
    logic [1:0] counter_value;
    logic       update_dropped;
  } out_item_t;

  typedef struct packed {
    logic [3:0] family;
    logic [1:0] hash_mode;
    logic [1:0] scope_sel;
    logic [7:0] update_delay;
    logic       barrier;
  } cfg_t;

  // queued update: path flag, direction flag, path hash, taken, counter, index
  typedef struct packed {
    logic       pth;
    logic       dir;
    logic [7:0] hash;
    logic       taken;
    logic [1:0] ctr;
    logic [7:0] idx;
  } upd_t;

  // front-to-back item: classified event
  typedef struct packed {
    logic [1:0]  kind;
    logic        taken;
    logic [7:0]  pc_idx;
    logic [7:0]  hash;
    logic        pth;
    logic [63:0] num;
  } ev_t;

  typedef enum logic [2:0] {
    BkIdle, BkDrainPre, BkLookup, BkResolve, BkDrainPost, BkFlush, BkOut
  } bk_state_t;

  function automatic logic [3:0] fam_eff(input logic [3:0] f);
    return (f <= FamTgtRoll) ? f : FamBimodal;
  endfunction

  function automatic logic with_history(input logic [3:0] f);
    logic [3:0] e;
    e = fam_eff(f);
    return e != FamBimodal && e != FamTgtLast && e != FamTgtRoll;
  endfunction

  function automatic logic with_path(input logic [3:0] f);
    logic [3:0] e;
    e = fam_eff(f);
    return e != FamBimodal && e != FamGshare;
  endfunction

  function automatic logic target_family(input logic [3:0] f);
    logic [3:0] e;
    e = fam_eff(f);
    return e == FamLastTgt || e == FamTgtPath || e == FamTgtLast || e == FamTgtRoll;
  endfunction

  function automatic logic [7:0] fold8(input logic [31:0] a);
    return a[9:2] ^ {4'd0, a[13:10]};
  endfunction

  function automatic logic [7:0] hash_target(input logic [31:0] a, input logic [1:0] m);
    logic [29:0] w;
    logic [7:0]  r;
    w = a[31:2];
    case (m)
      HashLow8:  r = w[7:0];
      HashFold4: r = {4'd0, w[3:0] ^ w[7:4] ^ w[11:8]};
      HashFold2: r = {6'd0, w[1:0] ^ w[3:2] ^ w[5:4] ^ w[7:6] ^ w[9:8] ^ w[11:10]};
      default:   r = fold8(a);
    endcase
    return r;
  endfunction

  function automatic logic [7:0] spread_path(input logic [7:0] p, input logic [1:0] m);
    logic [7:0] r;
    case (m)
      HashFold4: r = {p[3:0], p[3:0]};
      HashFold2: r = {p[1:0], p[1:0], p[1:0], p[1:0]};
      default:   r = p;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] path_next(input logic [7:0] p, input logic [7:0] h,
                                           input logic [3:0] f, input logic [1:0] m);
    logic [3:0] e;
    logic [7:0] r;
    e = fam_eff(f);
    if (e == FamLastTgt || e == FamTgtLast) begin
      r = h;
    end else if (m == HashFold2) begin
      r = {6'd0, {p[0], p[1]} ^ h[1:0]};
    end else if (m == HashFold4) begin
      r = {4'd0, {p[2:0], p[3]} ^ h[3:0]};
    end else begin
      r = {p[6:0], p[7]} ^ h;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/path_history_branch_predictor.sv
// Top level of the path-history branch predictor.
//
// Input channel in_valid/in_stall/in_data carries one committed control-flow
// event per word; output channel out_valid/out_stall/out_data returns one
// prediction word per event, in order. Configuration writes use cfg_valid,
// cfg_ready, cfg_index and cfg_data; the user must make them only while the
// block idles, since the block itself does not enforce this. A two-entry event
// queue separates the accepting front end from the back end, which runs one
// event at a time through a sequencer. Per event, the back end drains due
// queued updates, looks up and resolves the counter and loads the output
// register; a zero delay or a mispredict barrier adds a drain after the new
// update is queued. A new event is taken only after the last one is output.
// Reset loads the default registers and clears history, path signature, queue
// pointers and counter valid bits; unwritten counters read weakly not taken.
// When out_stall holds, the output register holds its word, the back end
// waits with the next result and the front queue fills until in_stall rises.
module path_history_branch_predictor
  import phbp_pkg::*;
#(
  parameter int unsigned PENDING_DEPTH = PendingDepthDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t cfg_r;
  logic ev_valid, ev_ready;
  ev_t  ev_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.family    <= FamGshare;
      cfg_r.hash_mode <= HashFold8;
      cfg_r.scope_sel <= ScopeNone;
      cfg_r.update_delay <= 8'd0;
      cfg_r.barrier   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegFamily:  cfg_r.family       <= cfg_data[3:0];
        RegHash:    cfg_r.hash_mode    <= cfg_data[1:0];
        RegScope:   cfg_r.scope_sel    <= cfg_data[1:0];
        RegDelay:   cfg_r.update_delay <= cfg_data;
        RegBarrier: cfg_r.barrier      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  phbp_front u_front (
    .clk, .rst_n, .cfg(cfg_r), .in_valid, .in_stall, .in_data,
    .ev_valid, .ev_ready, .ev_data
  );

  phbp_back #(.PENDING_DEPTH(PENDING_DEPTH)) u_back (
    .clk, .rst_n, .cfg(cfg_r), .ev_valid, .ev_ready, .ev_data,
    .out_valid, .out_stall, .out_data
  );

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");
  a_pred_counter: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.pred_taken == out_data.counter_value[1])
    else $error("prediction does not match counter");

endmodule

FILE: rtl/core/phbp_front.sv
// Front end: accepts events, classifies them and computes the path hash.
module phbp_front
  import phbp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     ev_valid,
  input  logic     ev_ready,
  output ev_t      ev_data
);

  // two-entry queue toward the back end
  ev_t        q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  ev_t        ev_new;
  logic       push, pop;
  logic [1:0] kind;
  logic       pth;

  always_comb begin
    kind = (in_data.func == FuncInvalid) ? FuncNone : in_data.func;
    pth = with_path(cfg.family) && kind != FuncNone && cfg.scope_sel != ScopeNone;
    if (cfg.scope_sel == ScopeBranch && kind != FuncBranch) pth = 1'b0;
    if (target_family(cfg.family) && !in_data.taken) pth = 1'b0;
    ev_new.kind   = kind;
    ev_new.taken  = in_data.taken;
    ev_new.pc_idx = in_data.source_address[9:2];
    ev_new.pth    = pth;
    ev_new.num    = in_data.instruction_number;
    case (fam_eff(cfg.family))
      FamLastTgt, FamTgtPath, FamTgtLast, FamTgtRoll:
        ev_new.hash = hash_target(in_data.target_address, cfg.hash_mode);
      FamSrcPath: ev_new.hash = fold8(in_data.source_address);
      FamNextPc:  ev_new.hash = fold8(in_data.next_address);
      FamEdge:    ev_new.hash = fold8(in_data.source_address) ^ fold8(in_data.next_address);
      default:    ev_new.hash = 8'd0;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign ev_valid = (cnt_r != 2'd0);
  assign ev_data  = q_r[rp_r];
  assign pop      = ev_valid && ev_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= ev_new;
  end

endmodule

FILE: rtl/core/phbp_back.sv
// Back end: drains due updates, looks up the counter table and queues updates.
module phbp_back
  import phbp_pkg::*;
#(
  parameter int unsigned PENDING_DEPTH = PendingDepthDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      ev_valid,
  output logic      ev_ready,
  input  ev_t       ev_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int unsigned PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int unsigned CW = $clog2(PENDING_DEPTH + 1);

  bk_state_t st_r, st_nxt;

  // counter table with valid bits (unwritten entries read weakly not taken)
  logic [1:0]            ctab_r [TableDepth];
  logic [TableDepth-1:0] cval_r;
  logic [1:0]            crd_r;
  logic                  crd_v_r;
  logic [7:0]            cwr_idx;
  logic [1:0]            cwr_val;
  logic                  cwr_en;
  logic                  crd_en;

  // pending queue memory
  logic [63:0] due_m  [PENDING_DEPTH];
  upd_t        upd_m  [PENDING_DEPTH];
  logic [63:0] head_due_r;
  upd_t        head_upd_r;
  logic [PW-1:0] head_r, head_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          qwr_en;
  logic [PW-1:0] tail;
  logic          head_fresh_r;
  logic          q_full;

  logic [7:0] gh_r, gh_nxt, ps_r, ps_nxt;
  ev_t        ev_r;
  logic [7:0] idx_r, idx_nxt;
  out_item_t  res_r, res_nxt;
  out_item_t  out_r;
  logic       out_load;
  logic       ov_r, ov_nxt;
  logic       apply;
  upd_t       new_upd;
  logic [63:0] new_due;
  logic       enq_need;

  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {{(CW+1-PW){1'b0}}, a} + {1'b0, b};
    if (s >= (CW+1)'(PENDING_DEPTH)) s = s - (CW+1)'(PENDING_DEPTH);
    return s[PW-1:0];
  endfunction

  assign tail     = wrap_add(head_r, cnt_r);
  assign q_full   = (cnt_r == CW'(PENDING_DEPTH));
  assign enq_need = (ev_r.kind == FuncBranch) || ev_r.pth;

  // the update is built from the result being resolved this cycle
  always_comb begin
    new_upd.pth   = ev_r.pth;
    new_upd.dir   = (ev_r.kind == FuncBranch);
    new_upd.hash  = ev_r.pth ? ev_r.hash : 8'd0;
    new_upd.taken = ev_r.taken;
    new_upd.ctr   = res_nxt.counter_value;
    new_upd.idx   = res_nxt.table_index;
    new_due       = ev_r.num + {56'd0, cfg.update_delay};
  end

  // head entry is valid to apply once its registered read is fresh
  always_comb begin
    st_nxt   = st_r;
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    gh_nxt   = gh_r;
    ps_nxt   = ps_r;
    idx_nxt  = idx_r;
    res_nxt  = res_r;
    ov_nxt   = ov_r;
    out_load = 1'b0;
    apply    = 1'b0;
    qwr_en   = 1'b0;
    cwr_en   = 1'b0;
    cwr_idx  = head_upd_r.idx;
    cwr_val  = head_upd_r.ctr;
    crd_en   = 1'b0;
    ev_ready = 1'b0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (st_r)
      BkIdle: begin
        ev_ready = 1'b1;
        if (ev_valid) st_nxt = BkDrainPre;
      end
      BkDrainPre, BkDrainPost, BkFlush: begin
        if (cnt_r == '0) begin
          st_nxt = (st_r == BkDrainPre) ? BkLookup : BkOut;
        end else if (head_fresh_r) begin
          if (st_r == BkFlush || head_due_r <= ev_r.num) begin
            apply = 1'b1;
          end else begin
            st_nxt = (st_r == BkDrainPre) ? BkLookup : BkOut;
          end
        end
      end
      BkLookup: begin
        idx_nxt = ev_r.pc_idx;
        if (with_history(cfg.family)) idx_nxt = idx_nxt ^ gh_r;
        if (with_path(cfg.family)) idx_nxt = idx_nxt ^ spread_path(ps_r, cfg.hash_mode);
        crd_en = 1'b1;
        st_nxt = BkResolve;
      end
      BkResolve: begin
        res_nxt = '0;
        if (ev_r.kind == FuncBranch) begin
          res_nxt.table_index   = idx_r;
          res_nxt.counter_value = crd_v_r ? crd_r : 2'd1;
          res_nxt.pred_taken    = res_nxt.counter_value[1];
          res_nxt.mispredicted  = res_nxt.counter_value[1] != ev_r.taken;
        end
        if (enq_need) begin
          // queue the update, or drop it when full, then pick the drain policy
          res_nxt.update_dropped = q_full;
          if (!q_full) begin
            qwr_en  = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end
          if (cfg.update_delay == 8'd0) st_nxt = BkDrainPost;
          else if (res_nxt.mispredicted && cfg.barrier) st_nxt = BkFlush;
          else st_nxt = BkOut;
        end else begin
          st_nxt = BkOut;
        end
      end
      BkOut: begin
        if (!ov_r || !out_stall) begin
          ov_nxt   = 1'b1;
          out_load = 1'b1;
          st_nxt   = BkIdle;
        end
      end
      default: st_nxt = BkIdle;
    endcase
    if (apply) begin
      head_nxt = wrap_add(head_r, CW'(1));
      cnt_nxt  = cnt_r - CW'(1);
      if (head_upd_r.dir) begin
        cwr_en = 1'b1;
        if (head_upd_r.taken) cwr_val = (head_upd_r.ctr == 2'd3) ? 2'd3 : head_upd_r.ctr + 2'd1;
        else cwr_val = (head_upd_r.ctr == 2'd0) ? 2'd0 : head_upd_r.ctr - 2'd1;
        if (with_history(cfg.family)) gh_nxt = {gh_r[6:0], head_upd_r.taken};
      end
      if (head_upd_r.pth) ps_nxt = path_next(ps_r, head_upd_r.hash, cfg.family, cfg.hash_mode);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= BkIdle;
      head_r       <= '0;
      cnt_r        <= '0;
      gh_r         <= 8'd0;
      ps_r         <= 8'd0;
      ov_r         <= 1'b0;
      cval_r       <= '0;
      head_fresh_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
      gh_r   <= gh_nxt;
      ps_r   <= ps_nxt;
      ov_r   <= ov_nxt;
      // refetch the head after a write to the queue
      head_fresh_r <= !qwr_en;
      if (cwr_en) cval_r[cwr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_ready && ev_valid) ev_r <= ev_data;
    idx_r <= idx_nxt;
    res_r <= res_nxt;
    if (out_load) out_r <= res_r;
    if (cwr_en) ctab_r[cwr_idx] <= cwr_val;
    if (crd_en) begin
      crd_r   <= ctab_r[idx_nxt];
      crd_v_r <= cval_r[idx_nxt];
    end
    if (qwr_en) begin
      due_m[tail] <= new_due;
      upd_m[tail] <= new_upd;
    end
    head_due_r <= due_m[head_nxt];
    head_upd_r <= upd_m[head_nxt];
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

endmodule
